[hw/rtl/clf_pkg.sv]
// shared types, event codes and character constants of the command line framer
`default_nettype none
package clf_pkg;

    localparam int LINE_BYTES_DEF = 80;
    localparam int SUM_W          = 16;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_RDY_REQ = 8'h14;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_STOP    = 8'h21;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_RESUME  = 8'h7E;
    localparam logic [7:0] CSUM_BASE  = 8'd128;

    localparam logic [1:0] OFS_PLAIN = 2'd0;
    localparam logic [1:0] OFS_CSUM  = 2'd2;

    typedef enum logic [3:0] {
        EV_IGNORED  = 4'd0,
        EV_STORED   = 4'd1,
        EV_OVERFLOW = 4'd2,
        EV_READY    = 4'd3,
        EV_DEFERRED = 4'd4,
        EV_STOP     = 4'd5,
        EV_RESUME   = 4'd6,
        EV_REFUSED  = 4'd7,
        EV_EXECUTE  = 4'd8,
        EV_STATUS   = 4'd9,
        EV_SKIPPED  = 4'd10,
        EV_TXERR    = 4'd11
    } t_event;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       planner_ready;
        logic       machine_stopped;
    } t_item_in;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] data_byte;
        logic [1:0] payload_offset;
        logic       range_err;
    } t_item_out;

    // per-line state apart from the byte count
    typedef struct packed {
        logic [7:0]       first_char;
        logic [7:0]       sent_csum;
        logic [7:0]       payload_first;
        logic [SUM_W-1:0] run_sum;
        logic             copy_acc;
    } t_line_state;

endpackage
`default_nettype wire

[hw/rtl/clf_step.sv]
// per-byte framing, checksum fold and line end verdict
`default_nettype none
module clf_step #(
    parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEF,
    localparam int CNT_W = $clog2(LINE_BYTES)
) (
    input  clf_pkg::t_item_in    i_item,
    input  logic [CNT_W-1:0]     i_count,
    input  clf_pkg::t_line_state i_state,
    output logic [CNT_W-1:0]     o_count,
    output clf_pkg::t_line_state o_state,
    output clf_pkg::t_item_out   o_res
);
    import clf_pkg::*;

    logic [7:0]       b;
    logic             is_end;
    logic             is_full;
    logic [CNT_W:0]   cnt_p1;
    logic [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0] expect_sum;
    logic             is_star;
    logic             is_csum;

    assign b          = i_item.rx_byte;
    assign is_end     = (b == CH_LF) || (b == CH_CR);
    assign cnt_p1     = {1'b0, i_count} + (CNT_W+1)'(1);
    assign is_full    = cnt_p1 >= (CNT_W+1)'(LINE_BYTES);
    assign sum_add    = i_state.run_sum + SUM_W'(b);
    assign expect_sum = {1'b0, i_state.run_sum[SUM_W-1:1]} + SUM_W'(CSUM_BASE);
    assign is_star    = i_state.first_char == CH_STAR;
    assign is_csum    = is_star || (i_state.first_char == CH_CARET);

    always_comb begin
        o_count = i_count;
        o_state = i_state;
        o_res   = '{event_res: EV_IGNORED, data_byte: 8'd0,
                    payload_offset: OFS_PLAIN, range_err: 1'b0};
        priority if (is_end) begin
            if (i_count != '0) begin
                // line end: verdict, then clear the line
                priority if (i_state.first_char == CH_STOP) begin
                    o_res.event_res = EV_STOP;
                end else if (i_state.first_char == CH_RESUME) begin
                    o_res.event_res = EV_RESUME;
                end else if (i_item.machine_stopped) begin
                    o_res.event_res = EV_REFUSED;
                end else if (!is_csum) begin
                    o_res.event_res = (i_state.first_char == CH_QUERY) ? EV_STATUS
                                                                       : EV_EXECUTE;
                end else if (i_state.copy_acc) begin
                    o_res.payload_offset = OFS_CSUM;
                    o_res.event_res      = EV_SKIPPED;
                    if (is_star) begin
                        o_state.copy_acc = 1'b0;
                    end
                end else begin
                    o_res.payload_offset = OFS_CSUM;
                    o_res.range_err      = i_state.sent_csum < CSUM_BASE;
                    if (expect_sum != {8'd0, i_state.sent_csum}) begin
                        o_res.event_res = is_star ? EV_TXERR : EV_SKIPPED;
                    end else begin
                        if (!is_star) begin
                            o_state.copy_acc = 1'b1;
                        end
                        o_res.event_res = (i_state.payload_first == CH_QUERY) ? EV_STATUS
                                                                              : EV_EXECUTE;
                    end
                end
                o_count               = '0;
                o_state.first_char    = 8'd0;
                o_state.sent_csum     = 8'd0;
                o_state.payload_first = 8'd0;
                o_state.run_sum       = '0;
            end
        end else if (is_full) begin
            o_res.event_res = EV_OVERFLOW;
        end else if (b == CH_RDY_REQ) begin
            o_res.event_res = i_item.planner_ready ? EV_READY : EV_DEFERRED;
        end else if (b <= CH_SPACE) begin
            o_res.event_res = EV_IGNORED;
        end else begin
            priority if (i_count == CNT_W'(0)) begin
                o_state.first_char = b;
            end else if (i_count == CNT_W'(1)) begin
                o_state.sent_csum = b;
            end else begin
                if (i_count == CNT_W'(2)) begin
                    o_state.payload_first = b;
                end
                // fold: take 128 off once when the sum reaches it
                o_state.run_sum = (sum_add >= SUM_W'(CSUM_BASE))
                                ? sum_add - SUM_W'(CSUM_BASE) : sum_add;
            end
            o_count         = cnt_p1[CNT_W-1:0];
            o_res.event_res = EV_STORED;
            o_res.data_byte = b;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/command_line_framer_checksum.sv]
// top level of the command line framer with checksum check
`default_nettype none
// Takes one host byte per item and gives one verdict item per byte. An item passes
// an input register and a result register with the combinational step between them, so
// a new byte is taken every cycle unless stalled, and its result is offered from the
// result register; output back-pressure stalls the input side only once both registers
// are full. Lines longer than LINE_BYTES - 1 stored bytes give overflow until CR or LF.
module command_line_framer_checksum #(
    parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // rx_byte, planner_ready, machine_stopped, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // data_byte, payload_offset, checksum_range_error, pad
    output logic [3:0]  o_m_tuser    // event_res
);
    import clf_pkg::*;

    localparam int CNT_W = $clog2(LINE_BYTES);

    logic                 r_in_valid;
    t_item_in             r_in;
    logic                 r_out_valid;
    t_item_out            r_out;
    logic [CNT_W-1:0]     r_count;
    t_line_state          r_state;
    logic [CNT_W-1:0]     n_count;
    t_line_state          n_state;
    t_item_out            n_out;
    logic                 advance;
    logic                 s_ready;

    assign advance = r_in_valid && (!r_out_valid || i_m_tready);
    assign s_ready = !r_in_valid || advance;

    clf_step #(
        .LINE_BYTES(LINE_BYTES)
    ) u_step (
        .i_item  (r_in),
        .i_count (r_count),
        .i_state (r_state),
        .o_count (n_count),
        .o_state (n_state),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_state     <= '0;
        end else begin
            if (s_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_in.rx_byte         <= i_s_tdata[7:0];
            r_in.planner_ready   <= i_s_tdata[8];
            r_in.machine_stopped <= i_s_tdata[9];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.event_res;
    assign o_m_tdata  = {5'd0, r_out.range_err, r_out.payload_offset, r_out.data_byte};

endmodule
`default_nettype wire
